[sv/pva_pkg.sv]
// Package for the polyphonic voice allocator: item and command types, op and
// action codes, field widths. No dependencies.

package pva_pkg;

    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 7;
    localparam int VID_W         = 4;
    localparam int AGE_W         = 32;
    localparam int VOICE_LIMIT_W = 5;
    localparam int RESULT_CAP    = 16;
    localparam int RES_CNT_W     = $clog2(RESULT_CAP + 1);
    localparam logic [VOICE_LIMIT_W-1:0] VOICE_LIMIT_RST = VOICE_LIMIT_W'(8);

    localparam logic [2:0] OP_NOTE_ON    = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF   = 3'd1;
    localparam logic [2:0] OP_PEDAL      = 3'd2;
    localparam logic [2:0] OP_VOICE_DONE = 3'd3;
    localparam logic [2:0] OP_ALL_OFF    = 3'd4;

    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_STEAL   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        K_NOTE_ON,
        K_NOTE_OFF,
        K_PEDAL_UP,
        K_VOICE_DONE,
        K_ALL_OFF
    } t_kind;

    typedef struct packed {
        logic [2:0]        op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              pedal_down;
        logic [VID_W-1:0]  done_voice;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        action;
        logic [VID_W-1:0]  voice_id;
        logic [NOTE_W-1:0] note_out;
        logic [VEL_W-1:0]  velocity_out;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_kind             kind;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              pedal;
        logic [VID_W-1:0]  done_voice;
    } t_cmd;

endpackage

[sv/pva_fifo.sv]
// Small show-ahead FIFO in flip-flops, used for the command and result queues.
// Depends on nothing; DEPTH must be a power of two, at least 2.

module pva_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/pva_front.sv]
// Front end of the voice allocator: accepts input items, tracks the pedal and
// turns items into commands for the back end. Depends on pva_pkg.

module pva_front import pva_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic  r_pedal;
    logic  accept;
    logic  keep;
    t_kind kind;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        keep = 1'b0;
        kind = K_ALL_OFF;
        unique case (i_item.op)
            OP_NOTE_ON: begin
                keep = 1'b1;
                kind = (i_item.velocity != '0) ? K_NOTE_ON : K_NOTE_OFF;
            end
            OP_NOTE_OFF: begin
                keep = 1'b1;
                kind = K_NOTE_OFF;
            end
            OP_PEDAL: begin
                keep = (i_item.pedal_down != r_pedal) && !i_item.pedal_down;
                kind = K_PEDAL_UP;
            end
            OP_VOICE_DONE: begin
                keep = 1'b1;
                kind = K_VOICE_DONE;
            end
            OP_ALL_OFF: begin
                keep = 1'b1;
                kind = K_ALL_OFF;
            end
            default: begin
                keep = 1'b0;
                kind = K_ALL_OFF;
            end
        endcase
    end

    assign o_q_push           = accept && keep;
    assign o_q_cmd.kind       = kind;
    assign o_q_cmd.note       = i_item.note;
    assign o_q_cmd.velocity   = i_item.velocity;
    assign o_q_cmd.pedal      = r_pedal;
    assign o_q_cmd.done_voice = i_item.done_voice;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pedal <= 1'b0;
        end else if (accept && (i_item.op == OP_PEDAL)) begin
            r_pedal <= i_item.pedal_down;
        end
    end

endmodule

[sv/pva_back.sv]
// Back end of the voice allocator: voice flags, note/age memory, the per-voice
// scan that picks, steals and releases voices. Depends on pva_pkg.

module pva_back import pva_pkg::*; #(
    parameter int MAX_VOICES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [VOICE_LIMIT_W-1:0] i_voice_limit,
    input  logic                     i_q_empty,
    input  t_cmd                     i_q_cmd,
    output logic                     o_q_pop,
    input  logic                     i_out_full,
    output logic                     o_out_push,
    output t_out_item                o_out_item
);

    localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam int LIM_W = (CNT_W > VOICE_LIMIT_W) ? CNT_W : VOICE_LIMIT_W;
    localparam int VX_W  = (IDX_W > VID_W) ? IDX_W : VID_W;
    localparam logic [LIM_W-1:0] MAX_L = LIM_W'(MAX_VOICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK
    } t_state;

    function automatic logic [VID_W-1:0] to_vid(input logic [IDX_W-1:0] idx);
        logic [VX_W-1:0] x;
        x = VX_W'(idx);
        return x[VID_W-1:0];
    endfunction

    t_state r_state;
    t_cmd   r_cmd;

    logic [MAX_VOICES-1:0] r_active;
    logic [MAX_VOICES-1:0] r_rel;
    logic [MAX_VOICES-1:0] r_held;
    logic [AGE_W-1:0]      r_next_order;

    logic [NOTE_W-1:0] mem_note [MAX_VOICES];
    logic [AGE_W-1:0]  mem_age  [MAX_VOICES];
    logic [NOTE_W-1:0] r_mem_note;
    logic [AGE_W-1:0]  r_mem_age;

    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_issuing;
    logic             r_ev_vld;
    logic [IDX_W-1:0] r_ev_idx;
    logic             r_ev_last;

    logic                 r_pend_vld;
    t_out_item            r_pend;
    logic [RES_CNT_W-1:0] r_emit_cnt;

    logic             r_free_vld;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_rel_vld;
    logic [IDX_W-1:0] r_rel_idx;
    logic [AGE_W-1:0] r_rel_age;
    logic             r_old_vld;
    logic [IDX_W-1:0] r_old_idx;
    logic [AGE_W-1:0] r_old_age;

    logic [LIM_W-1:0] lim_ext;
    logic [LIM_W-1:0] lim_l;
    logic [CNT_W-1:0] lim_c;
    logic             done_ok;
    logic [IDX_W-1:0] done_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] rd_next;
    logic             rd_en;
    logic             ev_act;
    logic             ev_rel;
    logic             ev_held;
    logic             ev_emit;
    logic             ev_set_rel;
    logic             ev_set_held;
    logic             ev_clr_held;
    logic             scan_ev;
    logic             emit_rep;
    logic             stall;
    t_out_item        rel_item;
    logic [IDX_W-1:0] pick_idx;
    t_out_item        pick_item;
    logic             wr_en;

    assign lim_ext = LIM_W'(i_voice_limit);
    assign lim_l   = (lim_ext == '0) ? LIM_W'(1) : ((lim_ext > MAX_L) ? MAX_L : lim_ext);
    assign lim_c   = lim_l[CNT_W-1:0];

    assign done_ok  = (int'(i_q_cmd.done_voice) < MAX_VOICES);
    assign done_idx = IDX_W'(i_q_cmd.done_voice);

    assign rd_idx  = r_rd_idx[IDX_W-1:0];
    assign rd_next = r_rd_idx + 1'b1;

    assign ev_act  = r_active[r_ev_idx];
    assign ev_rel  = r_rel[r_ev_idx];
    assign ev_held = r_held[r_ev_idx];

    always_comb begin
        ev_emit     = 1'b0;
        ev_set_rel  = 1'b0;
        ev_set_held = 1'b0;
        ev_clr_held = 1'b0;
        unique case (r_cmd.kind)
            K_NOTE_OFF: begin
                if (ev_act && (r_mem_note == r_cmd.note) && !ev_rel && !ev_held) begin
                    if (r_cmd.pedal) begin
                        ev_set_held = 1'b1;
                    end else begin
                        ev_set_rel = 1'b1;
                        ev_emit    = 1'b1;
                    end
                end
            end
            K_PEDAL_UP: begin
                ev_clr_held = ev_held;
                if (ev_held && ev_act && !ev_rel) begin
                    ev_set_rel = 1'b1;
                    ev_emit    = 1'b1;
                end
            end
            K_ALL_OFF: begin
                ev_clr_held = 1'b1;
                ev_set_rel  = ev_act;
                ev_emit     = ev_act;
            end
            default: begin
                ev_emit = 1'b0;
            end
        endcase
    end

    assign scan_ev  = (r_state == ST_SCAN) && r_ev_vld;
    assign emit_rep = scan_ev && ev_emit && (r_emit_cnt < RES_CNT_W'(RESULT_CAP));
    assign stall    = emit_rep && r_pend_vld && i_out_full;
    assign rd_en    = (r_state == ST_SCAN) && r_issuing && !stall;

    assign rel_item.action       = ACT_RELEASE;
    assign rel_item.voice_id     = to_vid(r_ev_idx);
    assign rel_item.note_out     = '0;
    assign rel_item.velocity_out = '0;
    assign rel_item.last         = 1'b0;

    assign pick_idx = r_free_vld ? r_free_idx : (r_rel_vld ? r_rel_idx : r_old_idx);
    assign pick_item.action       = r_active[pick_idx] ? ACT_STEAL : ACT_START;
    assign pick_item.voice_id     = to_vid(pick_idx);
    assign pick_item.note_out     = r_cmd.note;
    assign pick_item.velocity_out = r_cmd.velocity;
    assign pick_item.last         = 1'b1;

    assign wr_en   = (r_state == ST_PICK) && !i_out_full;
    assign o_q_pop = (r_state == ST_IDLE) && !i_q_empty;

    always_comb begin
        o_out_push = 1'b0;
        o_out_item = r_pend;
        unique case (r_state)
            ST_SCAN: begin
                o_out_push = emit_rep && r_pend_vld && !i_out_full;
            end
            ST_DRAIN: begin
                o_out_push      = r_pend_vld && !i_out_full;
                o_out_item.last = 1'b1;
            end
            ST_PICK: begin
                o_out_push = !i_out_full;
                o_out_item = pick_item;
            end
            default: begin
                o_out_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_note[pick_idx] <= r_cmd.note;
            mem_age[pick_idx]  <= r_next_order;
        end
        if (rd_en) begin
            r_mem_note <= mem_note[rd_idx];
            r_mem_age  <= mem_age[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_active     <= '0;
            r_rel        <= '0;
            r_held       <= '0;
            r_next_order <= AGE_W'(1);
            r_issuing    <= 1'b0;
            r_ev_vld     <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_emit_cnt   <= '0;
            r_free_vld   <= 1'b0;
            r_rel_vld    <= 1'b0;
            r_old_vld    <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd <= i_q_cmd;
                        if (i_q_cmd.kind == K_VOICE_DONE) begin
                            if (done_ok && r_active[done_idx]) begin
                                r_active[done_idx] <= 1'b0;
                                r_rel[done_idx]    <= 1'b0;
                                r_held[done_idx]   <= 1'b0;
                            end
                        end else begin
                            r_state    <= ST_SCAN;
                            r_len      <= (i_q_cmd.kind == K_NOTE_ON) ? lim_c
                                                                      : CNT_W'(MAX_VOICES);
                            r_rd_idx   <= '0;
                            r_issuing  <= 1'b1;
                            r_ev_vld   <= 1'b0;
                            r_pend_vld <= 1'b0;
                            r_emit_cnt <= '0;
                            r_free_vld <= 1'b0;
                            r_rel_vld  <= 1'b0;
                            r_old_vld  <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        if (r_issuing) begin
                            r_ev_vld  <= 1'b1;
                            r_ev_idx  <= rd_idx;
                            r_ev_last <= (rd_next == r_len);
                            r_rd_idx  <= rd_next;
                            if (rd_next == r_len) begin
                                r_issuing <= 1'b0;
                            end
                        end else begin
                            r_ev_vld <= 1'b0;
                        end
                        if (r_ev_vld) begin
                            if (ev_set_rel) begin
                                r_rel[r_ev_idx] <= 1'b1;
                            end
                            if (ev_set_held) begin
                                r_held[r_ev_idx] <= 1'b1;
                            end
                            if (ev_clr_held) begin
                                r_held[r_ev_idx] <= 1'b0;
                            end
                            if (emit_rep) begin
                                r_pend     <= rel_item;
                                r_pend_vld <= 1'b1;
                                r_emit_cnt <= r_emit_cnt + 1'b1;
                            end
                            if (r_cmd.kind == K_NOTE_ON) begin
                                if (!ev_act && !r_free_vld) begin
                                    r_free_vld <= 1'b1;
                                    r_free_idx <= r_ev_idx;
                                end
                                if (ev_rel && (!r_rel_vld || (r_mem_age < r_rel_age))) begin
                                    r_rel_vld <= 1'b1;
                                    r_rel_idx <= r_ev_idx;
                                    r_rel_age <= r_mem_age;
                                end
                                if (!r_old_vld || (r_mem_age < r_old_age)) begin
                                    r_old_vld <= 1'b1;
                                    r_old_idx <= r_ev_idx;
                                    r_old_age <= r_mem_age;
                                end
                            end
                            if (r_ev_last) begin
                                r_state <= (r_cmd.kind == K_NOTE_ON) ? ST_PICK : ST_DRAIN;
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!r_pend_vld) begin
                        r_state <= ST_IDLE;
                    end else if (!i_out_full) begin
                        r_pend_vld <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                ST_PICK: begin
                    if (!i_out_full) begin
                        r_active[pick_idx] <= 1'b1;
                        r_rel[pick_idx]    <= 1'b0;
                        r_held[pick_idx]   <= 1'b0;
                        if (r_next_order != '1) begin
                            r_next_order <= r_next_order + 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_rel_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rel & ~r_active) == '0)
        else $error("releasing voice is not active");

    a_held_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held & ~r_active) == '0)
        else $error("held voice is not active");

    a_order_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_order != '0)
        else $error("start order counter wrapped to zero");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into a full queue");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_pend_vld && (r_emit_cnt <= RES_CNT_W'(RESULT_CAP))))
        else $error("pending release left behind at idle");
`endif

endmodule

[sv/poly_voice_allocator.sv]
// Polyphonic voice allocator: assigns voices to note events, stealing the oldest
// releasing voice (else the oldest) when full; issues start, steal, release.
//
// Input queue side: an item (op, note, velocity, pedal_down, done_voice) is
// taken when push is high and full is low. Result queue side: the oldest
// result sits on o_result while empty is low and leaves when pop is high.
// The voice limit register is written through i_cfg_we / i_cfg_data.
// A front end classifies items into a two-entry command queue; the back end
// scans voices one per cycle through the note/age memory, unless the scan
// stalls on a full result queue. A note-on scans the first voice_limit
// voices and a note-off, pedal-up or all-notes-off scans all MAX_VOICES.
// A voice-done is handled without a scan; dropped items never reach the
// back end.
// The scan pauses while a release waits on the full four-entry result queue,
// so a stalled receiver backs up into full without losing items.
// Reset clears all voices and the pedal, restarts the start-order counter,
// and sets the voice limit to 8; no clearing pass is needed.
// Depends on pva_pkg, pva_fifo, pva_front and pva_back.

module poly_voice_allocator import pva_pkg::*; #(
    parameter int MAX_VOICES = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    input  t_in_item                 i_item,
    output logic                     full,
    input  logic                     pop,
    output t_out_item                o_result,
    output logic                     empty,
    input  logic                     i_cfg_we,
    input  logic [VOICE_LIMIT_W-1:0] i_cfg_data
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_out_item);

    logic [VOICE_LIMIT_W-1:0] r_voice_limit;

    logic             q_push;
    t_cmd             q_cmd_in;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [CMD_W-1:0] q_rdata;
    t_cmd             q_cmd_out;

    logic             out_push;
    t_out_item        out_item;
    logic             out_full;
    logic [RES_W-1:0] out_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_limit <= VOICE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_voice_limit <= i_cfg_data;
        end
    end

    pva_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd_in)
    );

    pva_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_cmd_out = t_cmd'(q_rdata);

    pva_back #(
        .MAX_VOICES (MAX_VOICES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_voice_limit (r_voice_limit),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_cmd_out),
        .o_q_pop       (q_pop),
        .i_out_full    (out_full),
        .o_out_push    (out_push),
        .o_out_item    (out_item)
    );

    pva_fifo #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign o_result = t_out_item'(out_rdata);

endmodule
